@@ rtl/interface_adapter_timers_tod_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the interface adapter
// Shorthands for clocked, reset-qualified concurrent checks on i_clk.
// ----------------------------------------------------------------------------
`ifndef INTERFACE_ADAPTER_TIMERS_TOD_ASSERT_SVH
`define INTERFACE_ADAPTER_TIMERS_TOD_ASSERT_SVH

// same-cycle implication
`define IATT_ASSERT_SAME(label, rst_n, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("iatt: check failed");

// next-cycle implication
`define IATT_ASSERT_NEXT(label, rst_n, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("iatt: check failed");

`endif

@@ rtl/iatt_pkg.sv @@
// ----------------------------------------------------------------------------
// iatt_pkg
// Types, register map and constants of the interface adapter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iatt_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_CYCLE = 2'd2,
        FUNC_TICK  = 2'd3
    } t_func;

    typedef struct packed {
        t_func      func;
        logic [3:0] addr;
        logic [7:0] wdata;
    } t_in_item;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq_request;
    } t_out_item;

    localparam int TOD_W = 26;

    // register map
    localparam logic [3:0] REG_PRA  = 4'h0;
    localparam logic [3:0] REG_PRB  = 4'h1;
    localparam logic [3:0] REG_DDRA = 4'h2;
    localparam logic [3:0] REG_DDRB = 4'h3;
    localparam logic [3:0] REG_TALO = 4'h4;
    localparam logic [3:0] REG_TAHI = 4'h5;
    localparam logic [3:0] REG_TBLO = 4'h6;
    localparam logic [3:0] REG_TBHI = 4'h7;
    localparam logic [3:0] REG_TOD10 = 4'h8;
    localparam logic [3:0] REG_TODS = 4'h9;
    localparam logic [3:0] REG_TODM = 4'hA;
    localparam logic [3:0] REG_TODH = 4'hB;
    localparam logic [3:0] REG_SDR  = 4'hC;
    localparam logic [3:0] REG_ICR  = 4'hD;
    localparam logic [3:0] REG_CRA  = 4'hE;
    localparam logic [3:0] REG_CRB  = 4'hF;

    // time-of-day register select, low address bits
    localparam logic [1:0] TOD_SEL_TENTHS = 2'd0;
    localparam logic [1:0] TOD_SEL_SEC    = 2'd1;
    localparam logic [1:0] TOD_SEL_MIN    = 2'd2;
    localparam logic [1:0] TOD_SEL_HOUR   = 2'd3;
    localparam logic [1:0] TOD_REG_GROUP  = 2'b10;

    localparam logic [7:0] CTRL_STORE_MASK = 8'hEF;
    localparam logic [7:0] CRA_RUN_MASK    = 8'h21;
    localparam logic [7:0] CRB_RUN_MASK    = 8'h61;
    localparam logic [7:0] CR_RUN_PHI      = 8'h01;
    localparam logic [7:0] CRB_RUN_CASCADE = 8'h41;
    localparam logic [7:0] HOUR_WR_MASK    = 8'h9F;
    localparam logic [7:0] PORT_RESET      = 8'hFF;
    localparam logic [15:0] COUNT_RESET    = 16'hFFFF;

    localparam logic [2:0] DIV_RELOAD_50HZ = 3'd4;
    localparam logic [2:0] DIV_RELOAD_60HZ = 3'd5;

    // interrupt flag bits
    localparam int FLAG_TA    = 0;
    localparam int FLAG_TB    = 1;
    localparam int FLAG_ALARM = 2;
    localparam int FLAG_SDR   = 3;
    localparam int FLAG_IR    = 7;

    typedef struct packed {
        logic       tick;
        logic       wr;
        logic [1:0] sel;
        logic [7:0] wdata;
        logic       to_alarm;
        logic       div_50hz;
    } t_tod_ctl;

endpackage

@@ rtl/iatt_chan_if.sv @@
// ----------------------------------------------------------------------------
// iatt_chan_if
// Valid/ready channel carrying one item payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface iatt_chan_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/iatt_tod.sv @@
// ----------------------------------------------------------------------------
// iatt_tod
// BCD time-of-day clock with tick divider, 12-hour wrap and alarm compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "interface_adapter_timers_tod_assert.svh"

module iatt_tod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  iatt_pkg::t_tod_ctl        i_ctl,
    output logic [iatt_pkg::TOD_W-1:0] o_clock_time,
    output logic                      o_alarm_hit
);

    logic [iatt_pkg::TOD_W-1:0] r_clock, n_clock;
    logic [iatt_pkg::TOD_W-1:0] r_alarm, n_alarm;
    logic [2:0]                 r_div, n_div;
    logic [iatt_pkg::TOD_W-1:0] w_adv;
    logic [iatt_pkg::TOD_W-1:0] w_target;

    function automatic logic [iatt_pkg::TOD_W-1:0] f_advance(
        input logic [iatt_pkg::TOD_W-1:0] t
    );
        logic [iatt_pkg::TOD_W-1:0] r;
        logic [4:0] ten;
        logic [4:0] lo;
        logic [3:0] hi;
        logic [7:0] h;
        logic [7:0] hn;
        r   = t;
        ten = {1'b0, t[3:0]} + 5'd1;
        if (ten > 5'd9) begin
            ten = 5'd0;
            lo  = {1'b0, t[7:4]} + 5'd1;
            hi  = {1'b0, t[10:8]};
            if (lo > 5'd9) begin
                lo = 5'd0;
                hi = hi + 4'd1;
            end
            if (hi > 4'd5) begin
                r[10:4] = 7'd0;
                lo = {1'b0, r[14:11]} + 5'd1;
                hi = {1'b0, r[17:15]};
                if (lo > 5'd9) begin
                    lo = 5'd0;
                    hi = hi + 4'd1;
                end
                if (hi > 4'd5) begin
                    r[17:11] = 7'd0;
                    h  = r[25:18];
                    lo = {1'b0, h[3:0]} + 5'd1;
                    hi = {3'd0, h[4]};
                    if (lo > 5'd9) begin
                        lo = 5'd0;
                        hi = hi + 4'd1;
                    end
                    hn = {h[7], 1'b0, hi[1:0], lo[3:0]};
                    if (hn[4:0] > 5'h11) begin
                        hn = {~hn[7], 7'd0};
                    end
                    r[25:18] = hn;
                end else begin
                    r[17:11] = {hi[2:0], lo[3:0]};
                end
            end else begin
                r[10:4] = {hi[2:0], lo[3:0]};
            end
        end
        r[3:0] = ten[3:0];
        return r;
    endfunction

    assign w_adv        = f_advance(r_clock);
    assign o_clock_time = r_clock;
    assign w_target     = i_ctl.to_alarm ? r_alarm : r_clock;

    always_comb begin
        logic [iatt_pkg::TOD_W-1:0] wr_val;
        wr_val      = w_target;
        n_clock     = r_clock;
        n_alarm     = r_alarm;
        n_div       = r_div;
        o_alarm_hit = 1'b0;
        case (i_ctl.sel)
            iatt_pkg::TOD_SEL_TENTHS: wr_val[3:0]   = i_ctl.wdata[3:0];
            iatt_pkg::TOD_SEL_SEC:    wr_val[10:4]  = i_ctl.wdata[6:0];
            iatt_pkg::TOD_SEL_MIN:    wr_val[17:11] = i_ctl.wdata[6:0];
            default:                  wr_val[25:18] = i_ctl.wdata & iatt_pkg::HOUR_WR_MASK;
        endcase
        if (i_ctl.tick) begin
            if (r_div != 3'd0) begin
                n_div = r_div - 3'd1;
            end else begin
                n_div       = i_ctl.div_50hz ? iatt_pkg::DIV_RELOAD_50HZ
                                             : iatt_pkg::DIV_RELOAD_60HZ;
                n_clock     = w_adv;
                o_alarm_hit = (w_adv == r_alarm);
            end
        end else if (i_ctl.wr) begin
            if (i_ctl.to_alarm) begin
                n_alarm = wr_val;
            end else begin
                n_clock = wr_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
            r_alarm <= '0;
            r_div   <= 3'd0;
        end else begin
            r_clock <= n_clock;
            r_alarm <= n_alarm;
            r_div   <= n_div;
        end
    end

    `IATT_ASSERT_SAME(a_div_range, i_rst_n, 1'b1, r_div <= iatt_pkg::DIV_RELOAD_60HZ)
    `IATT_ASSERT_SAME(a_hit_on_tick, i_rst_n, o_alarm_hit, i_ctl.tick && r_div == 3'd0)
    `IATT_ASSERT_NEXT(a_div_holds_clock, i_rst_n, i_ctl.tick && r_div != 3'd0, $stable(r_clock))

endmodule

@@ rtl/interface_adapter_timers_tod.sv @@
// ----------------------------------------------------------------------------
// interface_adapter_timers_tod
// Sixteen-register interface adapter: two interval timers, BCD time-of-day
// clock with alarm, serial data register and interrupt flag/mask logic.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                      | handshake
//  i_item    | in  | func[1:0] addr[3:0] wdata[7:0] | valid/ready
//  o_result  | out | rdata[7:0] irq_request        | valid/ready
//
//  One item per cycle sustained while o_result is not stalled; an accepted item
//  passes through the input register, then the result register.
//  All state updates happen in the single pass from input to result register.
//  A stalled result holds the input register; i_item.ready drops only then.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "interface_adapter_timers_tod_assert.svh"

module interface_adapter_timers_tod (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iatt_chan_if.sink     i_item,
    iatt_chan_if.source   o_result
);

    iatt_pkg::t_in_item  r_in;
    logic                r_in_valid;
    iatt_pkg::t_out_item r_out, n_out;
    logic                r_out_valid;
    logic                w_proc;

    logic [7:0]  r_pra, n_pra, r_prb, n_prb, r_ddra, n_ddra, r_ddrb, n_ddrb;
    logic [15:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [15:0] r_latch_a, n_latch_a, r_latch_b, n_latch_b;
    logic [7:0]  r_ctrl_a, n_ctrl_a, r_ctrl_b, n_ctrl_b;
    logic [2:0]  r_run, n_run;
    logic [7:0]  r_sdr, n_sdr;
    logic [7:0]  r_flags, n_flags;
    logic [6:0]  r_mask, n_mask;

    iatt_pkg::t_tod_ctl          w_tod_ctl;
    logic [iatt_pkg::TOD_W-1:0]  w_clock_time;
    logic                        w_alarm_hit;
    logic                        w_raise;
    logic                        w_irq_set;
    logic                        w_a_under;
    logic [7:0]                  w_rd;

    assign w_proc         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || w_proc;
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    assign w_tod_ctl.tick     = w_proc && (r_in.func == iatt_pkg::FUNC_TICK);
    assign w_tod_ctl.wr       = w_proc && (r_in.func == iatt_pkg::FUNC_WRITE)
                                && (r_in.addr[3:2] == iatt_pkg::TOD_REG_GROUP);
    assign w_tod_ctl.sel      = r_in.addr[1:0];
    assign w_tod_ctl.wdata    = r_in.wdata;
    assign w_tod_ctl.to_alarm = r_ctrl_b[7];
    assign w_tod_ctl.div_50hz = r_ctrl_a[7];

    iatt_tod u_tod (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_tod_ctl),
        .o_clock_time (w_clock_time),
        .o_alarm_hit  (w_alarm_hit)
    );

    always_comb begin
        n_pra     = r_pra;
        n_prb     = r_prb;
        n_ddra    = r_ddra;
        n_ddrb    = r_ddrb;
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;
        n_latch_a = r_latch_a;
        n_latch_b = r_latch_b;
        n_ctrl_a  = r_ctrl_a;
        n_ctrl_b  = r_ctrl_b;
        n_run     = r_run;
        n_sdr     = r_sdr;
        n_flags   = r_flags;
        n_mask    = r_mask;
        w_raise   = 1'b0;
        w_irq_set = 1'b0;
        w_a_under = 1'b0;
        w_rd      = 8'd0;
        if (w_proc) begin
            case (r_in.func)
                iatt_pkg::FUNC_READ: begin
                    case (r_in.addr)
                        iatt_pkg::REG_PRA:   w_rd = r_pra;
                        iatt_pkg::REG_PRB:   w_rd = r_prb;
                        iatt_pkg::REG_DDRA:  w_rd = r_ddra;
                        iatt_pkg::REG_DDRB:  w_rd = r_ddrb;
                        iatt_pkg::REG_TALO:  w_rd = r_cnt_a[7:0];
                        iatt_pkg::REG_TAHI:  w_rd = r_cnt_a[15:8];
                        iatt_pkg::REG_TBLO:  w_rd = r_cnt_b[7:0];
                        iatt_pkg::REG_TBHI:  w_rd = r_cnt_b[15:8];
                        iatt_pkg::REG_TOD10: w_rd = {4'd0, w_clock_time[3:0]};
                        iatt_pkg::REG_TODS:  w_rd = {1'b0, w_clock_time[10:4]};
                        iatt_pkg::REG_TODM:  w_rd = {1'b0, w_clock_time[17:11]};
                        iatt_pkg::REG_TODH:  w_rd = w_clock_time[25:18];
                        iatt_pkg::REG_SDR:   w_rd = r_sdr;
                        iatt_pkg::REG_ICR: begin
                            w_rd    = r_flags;
                            n_flags = 8'd0;
                        end
                        iatt_pkg::REG_CRA:   w_rd = r_ctrl_a;
                        default:             w_rd = r_ctrl_b;
                    endcase
                end
                iatt_pkg::FUNC_WRITE: begin
                    case (r_in.addr)
                        iatt_pkg::REG_PRA:  n_pra  = r_in.wdata;
                        iatt_pkg::REG_PRB:  n_prb  = r_in.wdata;
                        iatt_pkg::REG_DDRA: n_ddra = r_in.wdata;
                        iatt_pkg::REG_DDRB: n_ddrb = r_in.wdata;
                        iatt_pkg::REG_TALO: n_latch_a[7:0] = r_in.wdata;
                        iatt_pkg::REG_TAHI: begin
                            n_latch_a[15:8] = r_in.wdata;
                            if (!r_ctrl_a[0]) begin
                                n_cnt_a = {r_in.wdata, r_latch_a[7:0]};
                            end
                        end
                        iatt_pkg::REG_TBLO: n_latch_b[7:0] = r_in.wdata;
                        iatt_pkg::REG_TBHI: begin
                            n_latch_b[15:8] = r_in.wdata;
                            if (!r_ctrl_b[0]) begin
                                n_cnt_b = {r_in.wdata, r_latch_b[7:0]};
                            end
                        end
                        iatt_pkg::REG_TOD10, iatt_pkg::REG_TODS,
                        iatt_pkg::REG_TODM, iatt_pkg::REG_TODH: begin
                        end
                        iatt_pkg::REG_SDR: begin
                            n_sdr = r_in.wdata;
                            n_flags[iatt_pkg::FLAG_SDR] = 1'b1;
                            w_raise = 1'b1;
                        end
                        iatt_pkg::REG_ICR: begin
                            if (r_in.wdata[7]) begin
                                n_mask = r_mask | r_in.wdata[6:0];
                                if (|(r_flags[4:0] & n_mask[4:0])) begin
                                    n_flags[iatt_pkg::FLAG_IR] = 1'b1;
                                    w_irq_set = 1'b1;
                                end
                            end else begin
                                n_mask = r_mask & ~r_in.wdata[6:0];
                            end
                        end
                        iatt_pkg::REG_CRA: begin
                            n_ctrl_a = r_in.wdata & iatt_pkg::CTRL_STORE_MASK;
                            if (r_in.wdata[4]) begin
                                n_cnt_a = r_latch_a;
                            end
                            n_run[0] = ((r_in.wdata & iatt_pkg::CRA_RUN_MASK)
                                        == iatt_pkg::CR_RUN_PHI);
                        end
                        default: begin
                            n_ctrl_b = r_in.wdata & iatt_pkg::CTRL_STORE_MASK;
                            if (r_in.wdata[4]) begin
                                n_cnt_b = r_latch_b;
                            end
                            n_run[1] = ((r_in.wdata & iatt_pkg::CRB_RUN_MASK)
                                        == iatt_pkg::CR_RUN_PHI);
                            n_run[2] = ((r_in.wdata & iatt_pkg::CRB_RUN_MASK)
                                        == iatt_pkg::CRB_RUN_CASCADE);
                        end
                    endcase
                end
                iatt_pkg::FUNC_CYCLE: begin
                    if (r_run[0]) begin
                        if (r_cnt_a == 16'd0) begin
                            w_a_under = 1'b1;
                            n_cnt_a   = r_latch_a;
                            if (r_ctrl_a[3]) begin
                                n_ctrl_a[0] = 1'b0;
                                n_run[0]    = 1'b0;
                            end
                            n_flags[iatt_pkg::FLAG_TA] = 1'b1;
                            w_raise = 1'b1;
                        end else begin
                            n_cnt_a = r_cnt_a - 16'd1;
                        end
                    end
                    // timer B counts cycles or timer A underflows, never both
                    if (r_run[1] || (r_run[2] && w_a_under)) begin
                        if (r_cnt_b == 16'd0) begin
                            n_cnt_b = r_latch_b;
                            if (r_ctrl_b[3]) begin
                                n_ctrl_b[0] = 1'b0;
                                n_run[2:1]  = 2'b00;
                            end
                            n_flags[iatt_pkg::FLAG_TB] = 1'b1;
                            w_raise = 1'b1;
                        end else begin
                            n_cnt_b = r_cnt_b - 16'd1;
                        end
                    end
                end
                default: begin
                    if (w_alarm_hit) begin
                        n_flags[iatt_pkg::FLAG_ALARM] = 1'b1;
                        w_raise = 1'b1;
                    end
                end
            endcase
        end
        n_out.rdata       = w_rd;
        n_out.irq_request = w_irq_set || (w_raise && (|(n_flags[6:0] & r_mask)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pra       <= iatt_pkg::PORT_RESET;
            r_prb       <= iatt_pkg::PORT_RESET;
            r_ddra      <= 8'd0;
            r_ddrb      <= 8'd0;
            r_cnt_a     <= iatt_pkg::COUNT_RESET;
            r_cnt_b     <= iatt_pkg::COUNT_RESET;
            r_latch_a   <= 16'd0;
            r_latch_b   <= 16'd0;
            r_ctrl_a    <= 8'd0;
            r_ctrl_b    <= 8'd0;
            r_run       <= 3'd0;
            r_sdr       <= 8'd0;
            r_flags     <= 8'd0;
            r_mask      <= 7'd0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            r_pra     <= n_pra;
            r_prb     <= n_prb;
            r_ddra    <= n_ddra;
            r_ddrb    <= n_ddrb;
            r_cnt_a   <= n_cnt_a;
            r_cnt_b   <= n_cnt_b;
            r_latch_a <= n_latch_a;
            r_latch_b <= n_latch_b;
            r_ctrl_a  <= n_ctrl_a;
            r_ctrl_b  <= n_ctrl_b;
            r_run     <= n_run;
            r_sdr     <= n_sdr;
            r_flags   <= n_flags;
            r_mask    <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.payload;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    `IATT_ASSERT_SAME(a_stall_only_on_full, i_rst_n, r_in_valid && !i_item.ready, r_out_valid && !o_result.ready)
    `IATT_ASSERT_SAME(a_run_b_exclusive, i_rst_n, 1'b1, !(r_run[1] && r_run[2]))
    `IATT_ASSERT_SAME(a_ctrl_bit4_clear, i_rst_n, 1'b1, !r_ctrl_a[4] && !r_ctrl_b[4])
    `IATT_ASSERT_SAME(a_ir_from_mask_write, i_rst_n, $rose(r_flags[iatt_pkg::FLAG_IR]), $past(w_proc && r_in.func == iatt_pkg::FUNC_WRITE && r_in.addr == iatt_pkg::REG_ICR))

endmodule
